// File: rtl/alkd_pkg.sv
package alkd_pkg;

  localparam int NUM_KEYS  = 6;
  localparam int TOL_W     = 14;
  localparam int DEB_W     = 16;
  localparam int TIME_W    = 32;
  localparam int SAMPLE_W  = 14;
  localparam int PACK_A_W  = 56;
  localparam int PACK_B_W  = 28;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 56;

  typedef logic [2:0] key_t;

  localparam key_t KEY_NONE     = 3'd5;
  localparam key_t KEY_MULTIPLE = 3'd6;
  localparam key_t KEY_ERROR    = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_PACK_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_PACK_B = 3'd4;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_MIDPOINT = 1'b1;

  typedef struct packed {
    key_t stable;
    key_t prior;
  } deb_keys_t;

endpackage

// File: rtl/alkd_decode.sv
module alkd_decode import alkd_pkg::*; #(
  parameter int ADC_BITS = 14
) (
  input  logic [ADC_BITS-1:0] sample,
  input  logic [PACK_A_W-1:0] center_pack_a,
  input  logic [PACK_B_W-1:0] center_pack_b,
  input  logic                key_mode,
  input  logic [TOL_W-1:0]    tolerance,
  output key_t                decoded_key
);

  localparam int CMP_W = (ADC_BITS > TOL_W) ? ADC_BITS : TOL_W;

  logic [ADC_BITS-1:0] center [NUM_KEYS];
  logic [63:0]         wide_a;
  logic [63:0]         wide_b;
  key_t                nearest_key;
  key_t                mid_key;

  assign wide_a = 64'(center_pack_a);
  assign wide_b = 64'(center_pack_b);

  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (i < 4) begin
        center[i] = ADC_BITS'(wide_a >> (i * ADC_BITS));
      end else begin
        center[i] = ADC_BITS'(wide_b >> ((i - 4) * ADC_BITS));
      end
    end
  end

  always_comb begin
    logic [ADC_BITS-1:0] gap;
    logic [ADC_BITS-1:0] best_gap;
    key_t                best;
    logic                between;
    best_gap = '0;
    best     = '0;
    between  = 1'b0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      gap = (sample > center[i]) ? sample - center[i] : center[i] - sample;
      if (i == 0 || gap < best_gap) begin
        best_gap = gap;
        best     = key_t'(i);
      end
    end
    for (int i = 0; i < NUM_KEYS - 1; i++) begin
      if (sample > center[i] && sample < center[i+1]) begin
        between = 1'b1;
      end
    end
    if (CMP_W'(best_gap) <= CMP_W'(tolerance)) begin
      nearest_key = best;
    end else if (between) begin
      nearest_key = KEY_MULTIPLE;
    end else begin
      nearest_key = KEY_ERROR;
    end
  end

  always_comb begin
    logic [ADC_BITS:0]   sum;
    logic [ADC_BITS-1:0] mid;
    logic                found;
    mid_key = KEY_NONE;
    found   = 1'b0;
    for (int i = 0; i < NUM_KEYS - 1; i++) begin
      sum = {1'b0, center[i]} + {1'b0, center[i+1]};
      mid = sum[ADC_BITS:1];
      if (!found && sample < mid) begin
        mid_key = key_t'(i);
        found   = 1'b1;
      end
    end
  end

  assign decoded_key = (key_mode == MODE_MIDPOINT) ? mid_key : nearest_key;

endmodule

// File: rtl/alkd_debounce.sv
module alkd_debounce import alkd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  key_t              decoded_key,
  input  logic [TIME_W-1:0] now_ms,
  input  logic [DEB_W-1:0]  debounce_time,
  output deb_keys_t         keys_nxt
);

  key_t              cand_key_r;
  logic [TIME_W-1:0] cand_time_r;
  key_t              stable_r;
  key_t              prior_r;
  logic [TIME_W-1:0] cand_time_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              promote;

  assign cand_time_nxt = (decoded_key != cand_key_r) ? now_ms : cand_time_r;
  assign elapsed       = now_ms - cand_time_nxt;
  assign promote       = elapsed >= TIME_W'(debounce_time);

  assign keys_nxt.stable = promote ? decoded_key : stable_r;
  assign keys_nxt.prior  = promote ? stable_r : prior_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_key_r  <= KEY_NONE;
      cand_time_r <= '0;
      stable_r    <= KEY_NONE;
      prior_r     <= KEY_NONE;
    end else if (advance) begin
      cand_key_r  <= decoded_key;
      cand_time_r <= cand_time_nxt;
      stable_r    <= keys_nxt.stable;
      prior_r     <= keys_nxt.prior;
    end
  end

endmodule

// File: rtl/analog_ladder_keypad_decoder.sv
// Channel  Handshake            Payload
// in       in_valid/in_ready    in_sample[13:0], in_now_ms[31:0]
// out      out_valid/out_ready  out_decoded_key, out_stable_key, out_previous_key,
//                               out_key_changed
// cfg      cfg_valid/cfg_ready  cfg_index[2:0], cfg_data[55:0]
//
// One beat per cycle sustained while out_ready is high; a beat passes through the
// input register, then decode and debounce update into the result register.
// Synchronous active-low reset clears config registers and valid flags to zero, debounce keys to the no-key entry.
// cfg_ready is always high. A stalled result holds in the output register while
// the input register can still take one more beat.
module analog_ladder_keypad_decoder import alkd_pkg::*; #(
  parameter int ADC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  in_sample,
  input  logic [TIME_W-1:0]    in_now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output key_t                 out_decoded_key,
  output key_t                 out_stable_key,
  output key_t                 out_previous_key,
  output logic                 out_key_changed,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic                key_mode_r;
  logic [TOL_W-1:0]    tolerance_r;
  logic [DEB_W-1:0]    debounce_time_r;
  logic [PACK_A_W-1:0] pack_a_r;
  logic [PACK_B_W-1:0] pack_b_r;

  logic                s1_valid_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [TIME_W-1:0]   s1_now_r;

  logic                out_valid_r;
  key_t                out_decoded_r;
  key_t                out_stable_r;
  key_t                out_prior_r;

  logic                advance;
  logic [ADC_BITS-1:0] sample_adc;
  key_t                decoded;
  deb_keys_t           keys_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mode_r      <= MODE_NEAREST;
      tolerance_r     <= '0;
      debounce_time_r <= '0;
      pack_a_r        <= '0;
      pack_b_r        <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_MODE:      key_mode_r      <= cfg_data[0];
        REG_TOLERANCE:     tolerance_r     <= cfg_data[TOL_W-1:0];
        REG_DEBOUNCE_TIME: debounce_time_r <= cfg_data[DEB_W-1:0];
        REG_CENTER_PACK_A: pack_a_r        <= cfg_data[PACK_A_W-1:0];
        REG_CENTER_PACK_B: pack_b_r        <= cfg_data[PACK_B_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_sample;
      s1_now_r    <= in_now_ms;
    end
  end

  assign sample_adc = ADC_BITS'(s1_sample_r);

  alkd_decode #(
    .ADC_BITS(ADC_BITS)
  ) u_decode (
    .sample        (sample_adc),
    .center_pack_a (pack_a_r),
    .center_pack_b (pack_b_r),
    .key_mode      (key_mode_r),
    .tolerance     (tolerance_r),
    .decoded_key   (decoded)
  );

  alkd_debounce u_debounce (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .decoded_key   (decoded),
    .now_ms        (s1_now_r),
    .debounce_time (debounce_time_r),
    .keys_nxt      (keys_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_decoded_r <= decoded;
      out_stable_r  <= keys_nxt.stable;
      out_prior_r   <= keys_nxt.prior;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_decoded_key  = out_decoded_r;
  assign out_stable_key   = out_stable_r;
  assign out_previous_key = out_prior_r;
  assign out_key_changed  = out_stable_r != out_prior_r;

  a_free_slot_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stage empty but not ready");

  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a staged beat");

  a_stall_no_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !advance)
    else $error("stage advanced into a stalled result");

endmodule

// File: tb/sv/tb_analog_ladder_keypad_decoder.sv
`timescale 1ns / 100ps

module tb_analog_ladder_keypad_decoder;
  import alkd_pkg::*;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
  localparam logic [6*SAMPLE_W-1:0] LADDER = {14'd16000, 14'd13000, 14'd10000,
                                              14'd7000, 14'd4000, 14'd1000};
  localparam logic [6*SAMPLE_W-1:0] SCRAMBLED = {14'd12000, 14'd500, 14'd0,
                                                 14'd16383, 14'd2000, 14'd9000};

  typedef struct packed {
    key_t decoded;
    key_t stable;
    key_t previous;
    logic changed;
  } key_report_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  in_sample;
  logic [TIME_W-1:0]    in_now_ms;
  logic                 out_valid;
  logic                 out_ready;
  key_t                 out_decoded_key;
  key_t                 out_stable_key;
  key_t                 out_previous_key;
  logic                 out_key_changed;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // shadow registers and debounce state
  logic                mode_r   = MODE_NEAREST;
  logic [TOL_W-1:0]    tol_r    = '0;
  logic [DEB_W-1:0]    deb_r    = '0;
  logic [PACK_A_W-1:0] pack_a_r = '0;
  logic [PACK_B_W-1:0] pack_b_r = '0;
  key_t                cand_key_m   = KEY_NONE;
  logic [TIME_W-1:0]   cand_time_m  = '0;
  key_t                stable_key_m = KEY_NONE;
  key_t                prior_key_m  = KEY_NONE;

  key_report_t key_queue[$];
  key_report_t got_r;
  key_report_t want_r;

  int   errors       = 0;
  int   samples_sent = 0;
  int   reg_writes   = 0;
  int   key_changes  = 0;
  int   beats_seen   = 0;
  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;
  int   hold_cnt     = 0;
  logic hold_req     = 1'b0;

  analog_ladder_keypad_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_decoded_key  (out_decoded_key),
    .out_stable_key   (out_stable_key),
    .out_previous_key (out_previous_key),
    .out_key_changed  (out_key_changed),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("timeout with %0d beats outstanding", key_queue.size());
    $display("FAIL analog_ladder_keypad_decoder");
    $finish;
  end

  function automatic int center_at(input int i);
    if (i < 4) begin
      return int'(pack_a_r[i*SAMPLE_W +: SAMPLE_W]);
    end
    return int'(pack_b_r[(i-4)*SAMPLE_W +: SAMPLE_W]);
  endfunction

  function automatic key_t decode_sample(input logic [SAMPLE_W-1:0] smp);
    int c[NUM_KEYS];
    int s;
    int d;
    int best;
    int best_d;
    s = int'(smp);
    for (int i = 0; i < NUM_KEYS; i++) c[i] = center_at(i);
    if (mode_r == MODE_NEAREST) begin
      best = 0;
      best_d = 0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        d = (s > c[i]) ? s - c[i] : c[i] - s;
        if (i == 0 || d < best_d) begin
          best_d = d;
          best = i;
        end
      end
      if (best_d <= int'(tol_r)) return key_t'(best);
      for (int i = 0; i < NUM_KEYS - 1; i++) begin
        if (s > c[i] && s < c[i+1]) return KEY_MULTIPLE;
      end
      return KEY_ERROR;
    end
    for (int i = 0; i < NUM_KEYS - 1; i++) begin
      if (s < ((c[i] + c[i+1]) >> 1)) return key_t'(i);
    end
    return KEY_NONE;
  endfunction

  task automatic predict_keys(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
    key_t              dec;
    logic [TIME_W-1:0] elapsed;
    key_report_t       r;
    dec = decode_sample(s);
    if (dec != cand_key_m) begin
      cand_key_m = dec;
      cand_time_m = t;
    end
    elapsed = t - cand_time_m;
    if (elapsed >= {16'd0, deb_r}) begin
      prior_key_m = stable_key_m;
      stable_key_m = cand_key_m;
    end
    r.decoded = dec;
    r.stable = stable_key_m;
    r.previous = prior_key_m;
    r.changed = (stable_key_m != prior_key_m);
    if (r.changed) key_changes++;
    key_queue.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s at beat %0d: got %0d want %0d", what, beats_seen, got, want);
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      out_ready = 1'b0;
      hold_cnt--;
    end else begin
      out_ready = ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      got_r = {out_decoded_key, out_stable_key, out_previous_key, out_key_changed};
      if (key_queue.size() == 0) begin
        report_mismatch("unexpected beat", int'(got_r), 0);
      end else begin
        want_r = key_queue.pop_front();
        if (got_r.decoded != want_r.decoded)
          report_mismatch("decoded_key", int'(got_r.decoded), int'(want_r.decoded));
        if (got_r.stable != want_r.stable)
          report_mismatch("stable_key", int'(got_r.stable), int'(want_r.stable));
        if (got_r.previous != want_r.previous)
          report_mismatch("previous_key", int'(got_r.previous), int'(want_r.previous));
        if (got_r.changed != want_r.changed)
          report_mismatch("key_changed", int'(got_r.changed), int'(want_r.changed));
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = s;
    in_now_ms = t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_keys(s, t);
    samples_sent++;
  endtask

  // block is idle once every beat is back from the two-stage pipe
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (key_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val,
                           input int width);
    logic [CFG_DAT_W-1:0] mask;
    logic [CFG_DAT_W-1:0] data;
    wait_idle();
    mask = (width >= CFG_DAT_W) ? '1 : ((56'd1 << width) - 56'd1);
    data = CFG_DAT_W'({$urandom, $urandom});
    data = (data & ~mask) | (val & mask);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_KEY_MODE:      mode_r = data[0];
      REG_TOLERANCE:     tol_r = data[TOL_W-1:0];
      REG_DEBOUNCE_TIME: deb_r = data[DEB_W-1:0];
      REG_CENTER_PACK_A: pack_a_r = data[PACK_A_W-1:0];
      REG_CENTER_PACK_B: pack_b_r = data[PACK_B_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(input logic m, input logic [TOL_W-1:0] tol,
                               input logic [DEB_W-1:0] deb,
                               input logic [6*SAMPLE_W-1:0] cs);
    write_reg(REG_KEY_MODE, CFG_DAT_W'(m), 1);
    write_reg(REG_TOLERANCE, CFG_DAT_W'(tol), TOL_W);
    write_reg(REG_DEBOUNCE_TIME, CFG_DAT_W'(deb), DEB_W);
    write_reg(REG_CENTER_PACK_A, cs[PACK_A_W-1:0], PACK_A_W);
    write_reg(REG_CENTER_PACK_B, CFG_DAT_W'(cs[6*SAMPLE_W-1:PACK_A_W]), PACK_B_W);
  endtask

  function automatic logic [6*SAMPLE_W-1:0] random_centers();
    logic [6*SAMPLE_W-1:0] cs;
    int c;
    if ($urandom_range(7) == 0) begin
      for (int i = 0; i < NUM_KEYS; i++) cs[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom);
      return cs;
    end
    c = $urandom_range(0, 2000);
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (i > 0) c = c + $urandom_range(0, 3200);
      if (c > int'(SAMPLE_MAX)) c = int'(SAMPLE_MAX);
      cs[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(c);
    end
    return cs;
  endfunction

  function automatic logic [SAMPLE_W-1:0] near_center(input int k, input int j);
    int v;
    v = center_at(k) + int'($urandom_range(0, 2 * j)) - j;
    if (v < 0) v = 0;
    if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
    return SAMPLE_W'(v);
  endfunction

  task automatic test_reset_defaults();
    send_sample('0, '0);
    send_sample(SAMPLE_MAX, '1);
  endtask

  task automatic test_bad_index();
    for (int i = int'(REG_CENTER_PACK_B) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), '0, 0);
    end
    send_sample(14'd8000, 32'd10);
  endtask

  task automatic test_nearest();
    apply_setting(MODE_NEAREST, 14'd200, 16'd0, LADDER);
    send_sample(14'd1000, 32'd20);
    send_sample(14'd4100, 32'd21);
    send_sample(14'd2500, 32'd22);
    send_sample('0, 32'd23);
    send_sample(SAMPLE_MAX, 32'd24);
    send_sample(14'd16000, 32'd25);
    write_reg(REG_TOLERANCE, 56'd1500, TOL_W);
    send_sample(14'd2500, 32'd26);
    write_reg(REG_TOLERANCE, CFG_DAT_W'(SAMPLE_MAX), TOL_W);
    send_sample(SAMPLE_MAX, 32'd27);
  endtask

  task automatic test_midpoint();
    write_reg(REG_KEY_MODE, CFG_DAT_W'(MODE_MIDPOINT), 1);
    send_sample('0, 32'd30);
    send_sample(14'd2499, 32'd31);
    send_sample(14'd2500, 32'd32);
    send_sample(14'd14499, 32'd33);
    send_sample(14'd14500, 32'd34);
    send_sample(SAMPLE_MAX, 32'd35);
  endtask

  task automatic test_unordered();
    apply_setting(MODE_NEAREST, 14'd100, 16'd0, SCRAMBLED);
    send_sample(14'd1000, 32'd40);
    send_sample(14'd14000, 32'd41);
    write_reg(REG_KEY_MODE, CFG_DAT_W'(MODE_MIDPOINT), 1);
    send_sample(14'd5000, 32'd42);
  endtask

  task automatic test_debounce_wrap();
    apply_setting(MODE_NEAREST, SAMPLE_MAX, 16'd100, LADDER);
    send_sample(14'd1000, 32'hFFFF_FFC0);
    send_sample(14'd1010, 32'hFFFF_FFF0);
    send_sample(14'd990, 32'h0000_0030);
    send_sample(14'd1000, 32'h0000_0040);
    write_reg(REG_DEBOUNCE_TIME, 56'hFFFF, DEB_W);
    send_sample(14'd4000, 32'd5);
    send_sample(14'd4000, 32'd65539);
    send_sample(14'd4000, 32'd65540);
  endtask

  // mostly key presses held for a while with jitter, some raw noise and time jumps
  task automatic test_random(input int n);
    int sent;
    int quota;
    int k;
    int hold;
    int j;
    logic [TIME_W-1:0] t;
    logic [TOL_W-1:0]  tol;
    logic [DEB_W-1:0]  deb;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(7))
        0:       tol = '0;
        1:       tol = '1;
        default: tol = TOL_W'($urandom_range(0, 600));
      endcase
      case ($urandom_range(19))
        0, 1:    deb = '0;
        2:       deb = '1;
        default: deb = DEB_W'($urandom_range(0, 60));
      endcase
      apply_setting(1'($urandom_range(1)), tol, deb, random_centers());
      t = ($urandom_range(9) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
      quota = $urandom_range(30, 80);
      while (quota > 0 && sent < n) begin
        if ($urandom_range(99) < 80) begin
          k = $urandom_range(0, NUM_KEYS - 1);
          hold = $urandom_range(1, 12);
          j = int'(tol_r) + 40;
          if (j > 800) j = 800;
          repeat (hold) begin
            t = t + $urandom_range(0, 25);
            send_sample(near_center(k, j), t);
            sent++;
            quota--;
          end
        end else begin
          t = ($urandom_range(1) == 0) ? t + $urandom_range(0, 25) : $urandom;
          send_sample(SAMPLE_W'($urandom), t);
          sent++;
          quota--;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    logic [TIME_W-1:0] t;
    apply_setting(MODE_NEAREST, 14'd300, 16'd20, LADDER);
    hold_req = 1'b1;
    t = $urandom;
    for (int i = 0; i < 60; i++) begin
      t = t + $urandom_range(0, 10);
      send_sample(near_center(i / 10, 350), t);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_now_ms = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    snd_idle_pct = 21;
    rcv_idle_pct = 69;
    test_reset_defaults();
    test_bad_index();
    test_nearest();
    test_midpoint();
    test_unordered();
    test_debounce_wrap();
    test_random(420);

    snd_idle_pct = 69;
    rcv_idle_pct = 21;
    test_random(420);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_backpressure();
    test_random(420);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d samples, %0d register writes, both decode modes and idle mixes",
             samples_sent, reg_writes);
    $display("%0d beats checked, %0d stable-key changes, %0d mismatches",
             beats_seen, key_changes, errors);
    if (errors == 0 && key_queue.size() == 0) begin
      $display("PASS analog_ladder_keypad_decoder");
    end else begin
      $display("FAIL analog_ladder_keypad_decoder");
    end
    $finish;
  end

endmodule
